// ===== sv/lmbs_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and field widths for the local mean background subtractor.
package lmbs_pkg;

  localparam int unsigned PIX_W     = 16;
  localparam int unsigned COORD_W   = 10;
  localparam int unsigned REG_W     = 11;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned OUT_BURST = 8;
  localparam int unsigned BURST_W   = 4;

  localparam logic [REG_W-1:0] DIM_RESET = 11'd1024;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  localparam logic REG_IDX_WIDTH  = 1'b0;
  localparam logic REG_IDX_HEIGHT = 1'b1;

endpackage

// ===== sv/lmbs_if.sv =====
`timescale 1ns / 1ps
// Stream channel interfaces for pixel requests and subtraction results.
interface lmbs_in_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [lmbs_pkg::PIX_W-1:0] pixel_value;

  modport source (output valid, output req_type, output pixel_value, input ready);
  modport sink (input valid, input req_type, input pixel_value, output ready);
endinterface

interface lmbs_out_if;
  logic                         valid;
  logic                         ready;
  logic [lmbs_pkg::COORD_W-1:0] out_row;
  logic [lmbs_pkg::COORD_W-1:0] out_col;
  logic [lmbs_pkg::PIX_W-1:0]   excess_value;
  logic                         run_last;
  logic                         frame_last;

  modport source (output valid, output out_row, output out_col, output excess_value,
                  output run_last, output frame_last, input ready);
  modport sink (input valid, input out_row, input out_col, input excess_value,
                input run_last, input frame_last, output ready);
endinterface

// ===== sv/local_mean_background_subtract.sv =====
`timescale 1ns / 1ps
// Top level: raster local mean subtraction over a clipped square window.
//
// Pixels arrive in raster order; each result is max(pixel - floor(window mean), 0) for the
// (2*RADIUS+1)^2 window clipped to the image, emitted once its window has fully arrived,
// at most eight per input transaction, with drain transactions flushing the tail. The last
// 2*RADIUS+1 rows live in one synchronous pixel memory. An input transaction that releases
// no result passes only through the check state before input is taken again. Each result
// sums its clipped window of N pixels (up to 225 for radius 7), the memory read port
// giving one pixel a cycle, then runs TW steps of the bit-serial divider (TW is 24 by
// default) and waits out any output stall.
module local_mean_background_subtract #(
  parameter int unsigned RADIUS     = 7,
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lmbs_in_if.sink                       in_i,
  lmbs_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lmbs_pkg::APB_AW-1:0]   paddr,
  input  logic [lmbs_pkg::APB_DW-1:0]   pwdata,
  output logic [lmbs_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned WIN    = 2 * RADIUS + 1;
  localparam int unsigned RING_W = $clog2(WIN);
  localparam int unsigned DEPTH  = WIN * MAX_WIDTH;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CW     = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW     = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned DWC    = (CW > lmbs_pkg::REG_W) ? CW : lmbs_pkg::REG_W;
  localparam int unsigned DWR    = (RW > lmbs_pkg::REG_W) ? RW : lmbs_pkg::REG_W;
  localparam int unsigned KW     = $clog2(WIN * WIN + 1);
  localparam int unsigned TW     = PIXEL_BITS + KW;
  localparam int unsigned DCNT_W = $clog2(TW + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_SUM, ST_SUMEND, ST_DIVLOAD, ST_DIV, ST_RESULT, ST_PUSH
  } state_e;

  // configuration
  logic [lmbs_pkg::REG_W-1:0] width_q, height_q;
  logic                       cfg_wr;
  logic [CW-1:0]              w;
  logic [RW-1:0]              h;

  // control
  state_e                     state_q, state_d;
  logic [RW-1:0]              in_row_q, emit_row_q, r_q, r1_q;
  logic [CW-1:0]              in_col_q, emit_col_q, c_q, c0_q, c1_q;
  logic [RING_W-1:0]          in_ring_q, emit_ring_q, ring_q;
  logic [lmbs_pkg::BURST_W-1:0] n_q;
  logic                       done_q;
  logic                       acc_en_q, cen_en_q;
  logic [TW-1:0]              total_q, quo_q;
  logic [KW-1:0]              count_q, rem_q;
  logic [DCNT_W-1:0]          div_cnt_q;
  logic [PIXEL_BITS-1:0]      center_q;

  // held result and output register
  logic                       hold_valid_q, hold_last_q, hold_fl_q;
  logic [lmbs_pkg::COORD_W-1:0] hold_row_q, hold_col_q;
  logic [lmbs_pkg::PIX_W-1:0] hold_exc_q;
  logic                       out_valid_q, out_run_last_q, out_frame_last_q;
  logic [lmbs_pkg::COORD_W-1:0] out_row_q, out_col_q;
  logic [lmbs_pkg::PIX_W-1:0] out_exc_q;

  // memory
  logic [PIXEL_BITS-1:0]      mem [DEPTH];
  logic [PIXEL_BITS-1:0]      rdata_q;
  logic                       mem_we;
  logic [ADDR_W-1:0]          waddr, raddr;

  // window and readiness
  logic [RW:0]                er_ext, hm1_ext;
  logic [CW:0]                ec_ext, wm1_ext;
  logic [RW-1:0]              lr, r0;
  logic [CW-1:0]              lc, c0;
  logic [RING_W-1:0]          dr, ring0;
  logic                       win_rdy, avail, in_acc, pix_wr, out_free;
  logic [KW:0]                rem_next;
  logic [PIXEL_BITS-1:0]      mean;
  logic                       fl;

  function automatic logic [ADDR_W-1:0] mem_addr(logic [RING_W-1:0] ring, logic [CW-1:0] col);
    return ADDR_W'(ring) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
  endfunction

  function automatic logic [RING_W-1:0] ring_inc(logic [RING_W-1:0] ring);
    return (ring == RING_W'(WIN - 1)) ? '0 : ring + RING_W'(1);
  endfunction

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == lmbs_pkg::REG_IDX_HEIGHT)
                ? lmbs_pkg::APB_DW'(height_q) : lmbs_pkg::APB_DW'(width_q);

  // a zero dimension acts as one, an oversize one as the maximum
  always_comb begin
    if (width_q == '0) begin
      w = CW'(1);
    end else if (DWC'(width_q) > DWC'(MAX_WIDTH)) begin
      w = CW'(MAX_WIDTH);
    end else begin
      w = CW'(width_q);
    end
    if (height_q == '0) begin
      h = RW'(1);
    end else if (DWR'(height_q) > DWR'(MAX_HEIGHT)) begin
      h = RW'(MAX_HEIGHT);
    end else begin
      h = RW'(height_q);
    end
  end

  always_comb begin
    er_ext  = (RW + 1)'(emit_row_q) + (RW + 1)'(RADIUS);
    hm1_ext = (RW + 1)'(h) - (RW + 1)'(1);
    ec_ext  = (CW + 1)'(emit_col_q) + (CW + 1)'(RADIUS);
    wm1_ext = (CW + 1)'(w) - (CW + 1)'(1);
    lr      = (er_ext > hm1_ext) ? RW'(hm1_ext) : RW'(er_ext);
    lc      = (ec_ext > wm1_ext) ? CW'(wm1_ext) : CW'(ec_ext);
    r0      = (emit_row_q >= RW'(RADIUS)) ? emit_row_q - RW'(RADIUS) : '0;
    c0      = (emit_col_q >= CW'(RADIUS)) ? emit_col_q - CW'(RADIUS) : '0;
    dr      = RING_W'(emit_row_q - r0);
    ring0   = (emit_ring_q >= dr) ? emit_ring_q - dr : emit_ring_q + RING_W'(WIN) - dr;
    win_rdy = (lr < in_row_q) || ((lr == in_row_q) && (lc < in_col_q));
    avail   = !done_q && (n_q < lmbs_pkg::BURST_W'(lmbs_pkg::OUT_BURST))
              && (emit_row_q < h) && (emit_col_q < w) && win_rdy;
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign pix_wr     = in_acc && (in_i.req_type == lmbs_pkg::REQ_PIXEL)
                      && (in_row_q < h) && (in_col_q < w);
  assign mem_we     = pix_wr;
  assign waddr      = mem_addr(in_ring_q, in_col_q);
  assign raddr      = (state_q == ST_CHECK) ? mem_addr(emit_ring_q, emit_col_q)
                                            : mem_addr(ring_q, c_q);
  assign out_free   = !out_valid_q || out_o.ready;
  assign rem_next   = {rem_q, quo_q[TW-1]};
  assign mean       = quo_q[PIXEL_BITS-1:0];
  assign fl         = (emit_row_q == h - RW'(1)) && (emit_col_q == w - CW'(1));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= in_i.pixel_value[PIXEL_BITS-1:0];
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_acc) state_d = ST_CHECK;
      ST_CHECK: begin
        if (hold_valid_q) begin
          state_d = ST_PUSH;
        end else if (avail) begin
          state_d = ST_SUM;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SUM:     if ((c_q == c1_q) && (r_q == r1_q)) state_d = ST_SUMEND;
      ST_SUMEND:  state_d = ST_DIVLOAD;
      ST_DIVLOAD: state_d = ST_DIV;
      ST_DIV:     if (div_cnt_q == DCNT_W'(TW - 1)) state_d = ST_RESULT;
      ST_RESULT:  state_d = ST_CHECK;
      ST_PUSH:    if (out_free) state_d = hold_last_q ? ST_IDLE : ST_CHECK;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      width_q      <= lmbs_pkg::DIM_RESET;
      height_q     <= lmbs_pkg::DIM_RESET;
      in_row_q     <= '0;
      in_col_q     <= '0;
      in_ring_q    <= '0;
      emit_row_q   <= '0;
      emit_col_q   <= '0;
      emit_ring_q  <= '0;
      n_q          <= '0;
      done_q       <= 1'b0;
      acc_en_q     <= 1'b0;
      cen_en_q     <= 1'b0;
      hold_valid_q <= 1'b0;
      hold_last_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      acc_en_q <= (state_q == ST_SUM);
      cen_en_q <= (state_q == ST_CHECK) && !hold_valid_q && avail;

      // a register write restarts the frame
      if (cfg_wr) begin
        if (paddr[2] == lmbs_pkg::REG_IDX_HEIGHT) begin
          height_q <= pwdata[lmbs_pkg::REG_W-1:0];
        end else begin
          width_q <= pwdata[lmbs_pkg::REG_W-1:0];
        end
        in_row_q    <= '0;
        in_col_q    <= '0;
        in_ring_q   <= '0;
        emit_row_q  <= '0;
        emit_col_q  <= '0;
        emit_ring_q <= '0;
      end

      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (acc_en_q) begin
        total_q <= total_q + TW'(rdata_q);
        count_q <= count_q + KW'(1);
      end
      if (cen_en_q) begin
        center_q <= rdata_q;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            n_q    <= '0;
            done_q <= 1'b0;
          end
          if (pix_wr) begin
            if (in_col_q == w - CW'(1)) begin
              in_col_q  <= '0;
              in_row_q  <= in_row_q + RW'(1);
              in_ring_q <= ring_inc(in_ring_q);
            end else begin
              in_col_q <= in_col_q + CW'(1);
            end
          end
        end
        ST_CHECK: begin
          if (hold_valid_q) begin
            hold_last_q <= !avail;
          end else if (avail) begin
            r_q     <= r0;
            r1_q    <= lr;
            c_q     <= c0;
            c0_q    <= c0;
            c1_q    <= lc;
            ring_q  <= ring0;
            total_q <= '0;
            count_q <= '0;
          end
        end
        ST_SUM: begin
          if (c_q == c1_q) begin
            c_q    <= c0_q;
            r_q    <= r_q + RW'(1);
            ring_q <= ring_inc(ring_q);
          end else begin
            c_q <= c_q + CW'(1);
          end
        end
        ST_SUMEND: begin
        end
        ST_DIVLOAD: begin
          quo_q     <= total_q;
          rem_q     <= '0;
          div_cnt_q <= '0;
        end
        ST_DIV: begin
          // restoring division, one quotient bit a cycle
          if (rem_next >= {1'b0, count_q}) begin
            rem_q <= KW'(rem_next - {1'b0, count_q});
            quo_q <= {quo_q[TW-2:0], 1'b1};
          end else begin
            rem_q <= rem_next[KW-1:0];
            quo_q <= {quo_q[TW-2:0], 1'b0};
          end
          div_cnt_q <= div_cnt_q + DCNT_W'(1);
        end
        ST_RESULT: begin
          hold_valid_q <= 1'b1;
          hold_row_q   <= lmbs_pkg::COORD_W'(emit_row_q);
          hold_col_q   <= lmbs_pkg::COORD_W'(emit_col_q);
          hold_exc_q   <= lmbs_pkg::PIX_W'((center_q > mean) ? center_q - mean : '0);
          hold_fl_q    <= fl;
          n_q          <= n_q + lmbs_pkg::BURST_W'(1);
          if (fl) begin
            done_q      <= 1'b1;
            in_row_q    <= '0;
            in_col_q    <= '0;
            in_ring_q   <= '0;
            emit_row_q  <= '0;
            emit_col_q  <= '0;
            emit_ring_q <= '0;
          end else if (emit_col_q == w - CW'(1)) begin
            emit_col_q  <= '0;
            emit_row_q  <= emit_row_q + RW'(1);
            emit_ring_q <= ring_inc(emit_ring_q);
          end else begin
            emit_col_q <= emit_col_q + CW'(1);
          end
        end
        ST_PUSH: begin
          if (out_free) begin
            hold_valid_q     <= 1'b0;
            out_valid_q      <= 1'b1;
            out_row_q        <= hold_row_q;
            out_col_q        <= hold_col_q;
            out_exc_q        <= hold_exc_q;
            out_run_last_q   <= hold_last_q;
            out_frame_last_q <= hold_fl_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_row      = out_row_q;
  assign out_o.out_col      = out_col_q;
  assign out_o.excess_value = out_exc_q;
  assign out_o.run_last     = out_run_last_q;
  assign out_o.frame_last   = out_frame_last_q;

`ifndef SYNTHESIS
  a_no_accept_with_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !hold_valid_q) else $error("input taken while a result is held");
  a_burst_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= lmbs_pkg::BURST_W'(lmbs_pkg::OUT_BURST)) else $error("burst count overrun");
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (count_q != '0)) else $error("divide by empty window");
  a_write_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_IDLE)) else $error("pixel write outside idle");
`endif

endmodule
